### rtl/pre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_pkg
// shared constants and types of the printable run extractor
// ----------------------------------------------------------------------------
package pre_pkg;

   localparam int MAX_MIN_LEN = 64;
   localparam int BUF_DEPTH   = MAX_MIN_LEN - 1;
   localparam int BUF_AW      = $clog2(BUF_DEPTH);
   localparam int LEN_W       = 7;

   localparam int CMD_DEPTH   = 4;
   localparam int CMD_AW      = $clog2(CMD_DEPTH);
   localparam int CMD_CW      = $clog2(CMD_DEPTH + 1);

   localparam int OUT_DEPTH   = 4;
   localparam int OUT_AW      = $clog2(OUT_DEPTH);
   localparam int OUT_CW      = $clog2(OUT_DEPTH + 1);

   localparam logic [7:0]       TAB_BYTE       = 8'h09;
   localparam logic [7:0]       NEWLINE_BYTE   = 8'h0A;
   localparam logic [7:0]       PRINT_LOW      = 8'h20;
   localparam logic [7:0]       PRINT_HIGH     = 8'h7E;
   localparam logic [LEN_W-1:0] RESET_MIN_LEN  = LEN_W'(5);

   // command kinds
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_BURST = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [7:0]        data;
      logic [BUF_AW-1:0] count;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [BUF_AW-1:0] addr;
      logic [7:0]        data;
   } buf_wr_type;

endpackage

### rtl/printable_run_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printable_run_extractor
// passes on runs of printable bytes that reach a minimum length
// ----------------------------------------------------------------------------
// Bytes go in through a queue-like port (push/full) and results come out of
// one (pop/empty). Printable bytes (0x20 to 0x7e and tab) of a run are held
// until the run reaches csr_min_length, then the held bytes go out as one
// burst and later bytes pass straight through; a non-printable byte ends a
// passed-on run with a newline, and end_of_file clears the run silently.
// The front end takes one byte per cycle unless full. A byte that
// completes a held run of n bytes starts a burst of n+1 results that the
// back end replays through the run buffer's single read port at one entry
// per cycle unless its result queue is full; the input shows full until the
// replay is issued. last_of_burst marks each input byte's last result.
// ----------------------------------------------------------------------------
module printable_run_extractor import pre_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // input channel
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_file,
   // result channel
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_burst,
   // configuration
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_min_length
);

   // front to queue
   logic       cmd_push;
   cmd_type    cmd;
   logic       cmd_full;
   // queue to back
   logic       cmd_empty;
   cmd_type    cmd_head;
   logic       cmd_pop;
   // burst replay finished, front may take bytes again
   logic       burst_done;
   // run buffer writes come from the front
   buf_wr_type buf_wr;

   // run tracking and classification of each byte
   pre_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .csr_wr_en       (csr_wr_en),
      .csr_min_length  (csr_min_length),
      .cmd_full        (cmd_full),
      .burst_done      (burst_done),
      .cmd_push        (cmd_push),
      .cmd             (cmd),
      .buf_wr          (buf_wr)
   );

   // decouples the two halves
   pre_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (cmd_pop),
      .full      (cmd_full),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   // replays bursts and queues results for the output side
   pre_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_empty         (cmd_empty),
      .cmd_head          (cmd_head),
      .cmd_pop           (cmd_pop),
      .burst_done        (burst_done),
      .buf_wr            (buf_wr),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_burst (rsp_last_of_burst)
   );

endmodule

### rtl/pre_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_front
// accepts bytes, tracks the run and issues commands to the back end
// ----------------------------------------------------------------------------
module pre_front import pre_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_file,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_min_length,
   input  logic             cmd_full,
   input  logic             burst_done,
   output logic             cmd_push,
   output cmd_type          cmd,
   output buf_wr_type       buf_wr
);

   logic             in_run_ff, in_run_in;
   logic [LEN_W-1:0] run_len_ff, run_len_in;
   logic [LEN_W-1:0] min_len_ff;
   logic             burst_busy_ff, burst_busy_in;
   logic [LEN_W-1:0] eff_min;
   logic [LEN_W-1:0] len;
   logic             printable;
   logic             accept;
   logic             cmd_valid;

   always_comb begin
      priority if (min_len_ff == '0) begin
         eff_min = LEN_W'(1);
      end else if (min_len_ff > LEN_W'(MAX_MIN_LEN)) begin
         eff_min = LEN_W'(MAX_MIN_LEN);
      end else begin
         eff_min = min_len_ff;
      end
   end

   // a queued burst replays the buffer, so no new byte may overwrite it
   assign req_full  = cmd_full | burst_busy_ff;
   assign accept    = req_push & ~req_full;
   assign printable = ((req_data_byte >= PRINT_LOW) && (req_data_byte <= PRINT_HIGH))
                      || (req_data_byte == TAB_BYTE);
   assign len       = in_run_ff ? run_len_ff : '0;

   always_comb begin
      cmd_valid   = 1'b0;
      cmd.kind    = CMD_BYTE;
      cmd.data    = req_data_byte;
      cmd.count   = len[BUF_AW-1:0];
      cmd.last    = 1'b1;
      buf_wr.en   = 1'b0;
      buf_wr.addr = len[BUF_AW-1:0];
      buf_wr.data = req_data_byte;
      in_run_in   = in_run_ff;
      run_len_in  = run_len_ff;
      if (printable) begin
         if (len >= eff_min) begin
            cmd_valid = 1'b1;
         end else if (len + LEN_W'(1) == eff_min) begin
            cmd_valid = 1'b1;
            cmd.kind  = (len == '0) ? CMD_BYTE : CMD_BURST;
         end
         buf_wr.en  = accept && (len < LEN_W'(BUF_DEPTH));
         in_run_in  = 1'b1;
         run_len_in = (len < LEN_W'(MAX_MIN_LEN)) ? len + LEN_W'(1) : len;
      end else begin
         if (in_run_ff && (run_len_ff >= eff_min)) begin
            cmd_valid = 1'b1;
            cmd.data  = NEWLINE_BYTE;
         end
         in_run_in  = 1'b0;
         run_len_in = '0;
      end
      if (req_end_of_file) begin
         in_run_in  = 1'b0;
         run_len_in = '0;
      end
   end

   assign cmd_push = accept & cmd_valid;

   always_comb begin
      burst_busy_in = burst_busy_ff;
      if (cmd_push && (cmd.kind == CMD_BURST)) begin
         burst_busy_in = 1'b1;
      end else if (burst_done) begin
         burst_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff     <= 1'b0;
         run_len_ff    <= '0;
         min_len_ff    <= RESET_MIN_LEN;
         burst_busy_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_run_ff  <= in_run_in;
            run_len_ff <= run_len_in;
         end
         if (csr_wr_en) begin
            min_len_ff <= csr_min_length;
         end
         burst_busy_ff <= burst_busy_in;
      end
   end

endmodule

### rtl/pre_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_cmd_queue
// short command queue between front and back end
// ----------------------------------------------------------------------------
module pre_cmd_queue import pre_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   cmd_type           entry_ff [CMD_DEPTH];
   logic [CMD_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CMD_CW-1:0] count_ff;
   logic              do_push, do_pop;

   assign full    = (count_ff == CMD_CW'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + CMD_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMD_AW'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + CMD_CW'(1);
            2'b01:   count_ff <= count_ff - CMD_CW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### rtl/pre_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_back
// carries out commands: run buffer, burst replay and result queue
// ----------------------------------------------------------------------------
module pre_back import pre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_empty,
   input  cmd_type    cmd_head,
   output logic       cmd_pop,
   output logic       burst_done,
   input  buf_wr_type buf_wr,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_burst
);

   logic [7:0]        buf_mem [BUF_DEPTH];
   logic [7:0]        mem_q_ff;
   logic              rd_en;
   logic [BUF_AW-1:0] idx_ff, idx_in;

   logic              s_valid_ff;
   logic              s_from_mem_ff, s_from_mem_in;
   logic [7:0]        s_byte_ff;
   logic              s_last_ff, s_last_in;
   logic              issue;
   logic              can_issue;

   logic [8:0]        out_ff [OUT_DEPTH];
   logic [OUT_AW-1:0] out_wr_ff, out_rd_ff;
   logic [OUT_CW-1:0] out_cnt_ff;
   logic [OUT_CW:0]   out_need;
   logic              out_push, out_pop;
   logic [7:0]        s_out_byte;

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         buf_mem[buf_wr.addr] <= buf_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= buf_mem[idx_ff];
      end
   end

   // room for the item in flight plus the new one
   assign out_need  = {1'b0, out_cnt_ff} + (OUT_CW + 1)'(s_valid_ff);
   assign can_issue = (out_need < (OUT_CW + 1)'(OUT_DEPTH)) && !cmd_empty;

   always_comb begin
      issue         = 1'b0;
      rd_en         = 1'b0;
      cmd_pop       = 1'b0;
      burst_done    = 1'b0;
      idx_in        = idx_ff;
      s_from_mem_in = 1'b0;
      s_last_in     = cmd_head.last;
      if (can_issue) begin
         issue = 1'b1;
         if ((cmd_head.kind == CMD_BURST) && (idx_ff < cmd_head.count)) begin
            rd_en         = 1'b1;
            s_from_mem_in = 1'b1;
            s_last_in     = 1'b0;
            idx_in        = idx_ff + BUF_AW'(1);
         end else begin
            cmd_pop    = 1'b1;
            burst_done = (cmd_head.kind == CMD_BURST);
            idx_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s_from_mem_ff <= s_from_mem_in;
         s_byte_ff     <= cmd_head.data;
         s_last_ff     <= s_last_in;
      end
   end

   assign s_out_byte = s_from_mem_ff ? mem_q_ff : s_byte_ff;
   assign out_push   = s_valid_ff;
   assign out_pop    = rsp_pop & ~rsp_empty;

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ff] <= {s_last_ff, s_out_byte};
      end
   end

   assign rsp_empty         = (out_cnt_ff == '0);
   assign rsp_out_byte      = out_ff[out_rd_ff][7:0];
   assign rsp_last_of_burst = out_ff[out_rd_ff][8];

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         s_valid_ff <= 1'b0;
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         idx_ff     <= idx_in;
         s_valid_ff <= issue;
         if (out_push) begin
            out_wr_ff <= out_wr_ff + OUT_AW'(1);
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + OUT_AW'(1);
         end
         unique case ({out_push, out_pop})
            2'b10:   out_cnt_ff <= out_cnt_ff + OUT_CW'(1);
            2'b01:   out_cnt_ff <= out_cnt_ff - OUT_CW'(1);
            default: out_cnt_ff <= out_cnt_ff;
         endcase
      end
   end

endmodule

### bench/printable_run_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printable_run_extractor_tb
// self-checking regression of the printable run extractor
// ----------------------------------------------------------------------------
// A behavioural predictor tracks the run state, the run store and min_length,
// and queues the bytes that each accepted input transfer should produce.
// Every result transfer is checked field by field against the oldest queued
// byte. Directed tests cover the reset length, lengths of one and zero, and
// changes of min_length in the middle of a run. Random phases then send
// printable runs around the threshold, mixed with noise and end-of-file
// marks, under random idling on both sides.
// ----------------------------------------------------------------------------
module printable_run_extractor_tb import pre_pkg::*;;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_burst;
   } run_result_type;

   logic             clock             = 1'b0;
   logic             reset             = 1'b1;
   logic             req_push          = 1'b0;
   logic             req_full;
   logic [7:0]       req_data_byte     = 8'h00;
   logic             req_end_of_file   = 1'b0;
   logic             rsp_pop           = 1'b0;
   logic             rsp_empty;
   logic [7:0]       rsp_out_byte;
   logic             rsp_last_of_burst;
   logic             csr_wr_en         = 1'b0;
   logic [LEN_W-1:0] csr_min_length    = RESET_MIN_LEN;

   // predictor state: mirrors the run tracking of the block
   logic             run_open;
   logic [LEN_W-1:0] run_count;
   logic [7:0]       run_store [BUF_DEPTH];
   logic [LEN_W-1:0] min_len_reg;

   // bytes still due out of the block, oldest first
   run_result_type   due_bytes [$];

   int               mismatches  = 0;
   int               pop_hold    = 0;
   bit               steady_flow = 1'b0;   // when set, neither side idles

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   printable_run_extractor u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_end_of_file   (req_end_of_file),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_burst (rsp_last_of_burst),
      .csr_wr_en         (csr_wr_en),
      .csr_min_length    (csr_min_length)
   );

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic bit is_text_byte(logic [7:0] b);
      return (b >= PRINT_LOW && b <= PRINT_HIGH) || b == TAB_BYTE;
   endfunction

   // zero counts as one, anything past MAX_MIN_LEN saturates to it
   function automatic int run_threshold();
      if (min_len_reg == 0)
         return 1;
      if (min_len_reg > MAX_MIN_LEN)
         return MAX_MIN_LEN;
      return int'(min_len_reg);
   endfunction

   function automatic void scan_byte(logic [7:0] b, logic eof);
      run_result_type burst [$];
      int             m;
      int             len;
      m = run_threshold();
      if (is_text_byte(b)) begin
         if (!run_open) begin
            run_open  = 1'b1;
            run_count = '0;
         end
         len = int'(run_count);
         if (len >= m) begin
            // run already passed on: straight through
            burst.push_back({b, 1'b0});
         end else if (len + 1 == m) begin
            // run just reached the threshold: replay the held opening bytes
            for (int i = 0; i < len && i < BUF_DEPTH; i++)
               burst.push_back({run_store[i], 1'b0});
            burst.push_back({b, 1'b0});
         end
         if (len < BUF_DEPTH)
            run_store[len] = b;
         if (len < MAX_MIN_LEN)
            run_count = LEN_W'(len + 1);
      end else begin
         // a control byte closes the run, with a newline only if it was passed on
         if (run_open && run_count >= m)
            burst.push_back({NEWLINE_BYTE, 1'b0});
         run_open  = 1'b0;
         run_count = '0;
      end
      // end of file drops the run silently, after the byte itself
      if (eof) begin
         run_open  = 1'b0;
         run_count = '0;
      end
      if (burst.size() > 0)
         burst[burst.size()-1].last_of_burst = 1'b1;
      foreach (burst[i])
         due_bytes.push_back(burst[i]);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_len();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 15) == 0)
         return TAB_BYTE;
      return 8'($urandom_range(int'(PRINT_LOW), int'(PRINT_HIGH)));
   endfunction

   function automatic logic [7:0] control_byte();
      logic [7:0] b;
      do
         b = 8'($urandom);
      while (is_text_byte(b));
      return b;
   endfunction

   // one input transfer; push stays high afterwards so the next byte can
   // follow back to back
   task automatic push_byte(logic [7:0] b, logic eof);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_data_byte   <= b;
      req_end_of_file <= eof;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      scan_byte(b, eof);
   endtask

   // sender holds off until every due byte has come out
   task automatic hold_until_drained();
      req_push <= 1'b0;
      while (due_bytes.size() != 0)
         @(posedge clock);
   endtask

   // drained, plus room for a burst replay still in flight
   task automatic settle();
      hold_until_drained();
      repeat (100) @(posedge clock);
   endtask

   task automatic write_min_length(logic [LEN_W-1:0] v);
      settle();
      csr_wr_en      <= 1'b1;
      csr_min_length <= v;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      min_len_reg     = v;
   endtask

   // ------------------------------------------------------------------------
   // result side: random pop stalls and the checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_hold > 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         rsp_pop  <= 1'b1;
         pop_hold <= idle_len();
      end
   end

   task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
      $display("%0t: %s mismatch, got %02h want %02h", $time, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      run_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (due_bytes.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_out_byte, 8'h00);
         end else begin
            want = due_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_last_of_burst !== want.last_of_burst)
               report_mismatch("last_of_burst", 8'(rsp_last_of_burst),
                               8'(want.last_of_burst));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset length of five: a short run is dropped, a full one bursts out
   task automatic test_default_length();
      push_byte("a", 1'b0);
      push_byte("b", 1'b0);
      push_byte(8'h0A, 1'b0);
      push_byte(8'h20, 1'b0);
      push_byte(8'h7E, 1'b0);
      push_byte(TAB_BYTE, 1'b0);
      push_byte("x", 1'b0);
      push_byte("y", 1'b0);
      push_byte(8'hFF, 1'b1);
   endtask

   // printable bytes pass at once, runs closed by control bytes get a newline
   task automatic test_single_byte_runs();
      write_min_length(LEN_W'(1));
      push_byte(8'h7E, 1'b0);
      push_byte(8'h1F, 1'b0);
      push_byte(8'h80, 1'b1);
      push_byte("Z", 1'b1);
   endtask

   // a length of zero behaves as one
   task automatic test_zero_length();
      write_min_length(LEN_W'(0));
      push_byte("q", 1'b0);
      push_byte(8'h00, 1'b0);
   endtask

   // held bytes are dropped when the threshold falls below the count
   task automatic test_lowered_while_held();
      write_min_length(LEN_W'(6));
      push_byte("h", 1'b0);
      push_byte("e", 1'b0);
      push_byte("l", 1'b0);
      push_byte("d", 1'b0);
      write_min_length(LEN_W'(3));
      push_byte("!", 1'b0);
      push_byte(8'h00, 1'b0);
   endtask

   // raising the threshold mid run replays the opening bytes once more
   task automatic test_raised_while_passing();
      write_min_length(LEN_W'(2));
      push_byte("p", 1'b0);
      push_byte("q", 1'b0);
      write_min_length(LEN_W'(4));
      push_byte("r", 1'b0);
      push_byte("s", 1'b0);
      push_byte(8'h7F, 1'b0);
   endtask

   // runs of random length and content with noise; a phase may stop in the
   // middle of a run, so the next setting lands on a live run
   task automatic test_random_runs(logic [LEN_W-1:0] setting, int n_items,
                                   int shortest, int longest);
      int sent;
      int len;
      int r;
      write_min_length(setting);
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            push_byte(8'($urandom), $urandom_range(0, 7) == 0);
            sent++;
         end else if (r < 15) begin
            hold_until_drained();
         end else begin
            len = $urandom_range(shortest, longest);
            for (int i = 0; i < len && sent < n_items; i++) begin
               push_byte(text_byte(), i == len - 1 && $urandom_range(0, 9) == 0);
               sent++;
            end
            if (sent < n_items) begin
               push_byte(control_byte(), $urandom_range(0, 9) == 0);
               sent++;
            end
         end
      end
   endtask

   // back to back on both sides for a whole phase
   task automatic test_steady_stream();
      steady_flow = 1'b1;
      test_random_runs(LEN_W'(8), 50, 1, 12);
      steady_flow = 1'b0;
   endtask

   // longest runs: full store replay at 64, and saturation above it
   task automatic test_longest_runs();
      test_random_runs(LEN_W'(MAX_MIN_LEN), 70, 60, 70);
      test_random_runs(LEN_W'(127), 70, 62, 70);
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      min_len_reg = RESET_MIN_LEN;
      run_open    = 1'b0;
      run_count   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_default_length();
      test_single_byte_runs();
      test_zero_length();
      test_lowered_while_held();
      test_raised_while_passing();

      test_random_runs(LEN_W'(1), 40, 1, 6);
      test_random_runs(LEN_W'(3), 50, 1, 8);
      test_steady_stream();
      test_random_runs(LEN_W'(16), 45, 4, 20);
      test_longest_runs();
      test_random_runs(LEN_W'(2), 20, 1, 5);

      settle();
      if (mismatches == 0)
         $display("printable_run_extractor regression: pass");
      else
         $display("printable_run_extractor regression: fail");
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #60ms;
      $display("printable_run_extractor regression: fail");
      $finish;
   end

endmodule
